// ===== hw/rtl/i2cbb_pkg.sv =====
// Package for the I2C bit-bang master: field widths, command codes,
// configuration register indexes, reset values and the phase encoding.
// No dependencies.
package i2cbb_pkg;

    // Field widths
    localparam int FuncW    = 3;
    localparam int ByteW    = 8;
    localparam int PauseW   = 16;
    localparam int StretchW = 9;
    localparam int BitIdxW  = 4;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;

    // Command codes carried in func
    localparam logic [FuncW-1:0] FUNC_TICK  = 3'd0;
    localparam logic [FuncW-1:0] FUNC_START = 3'd1;
    localparam logic [FuncW-1:0] FUNC_STOP  = 3'd2;
    localparam logic [FuncW-1:0] FUNC_WRITE = 3'd3;
    localparam logic [FuncW-1:0] FUNC_READ  = 3'd4;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_PAUSE_TICKS   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_STRETCH_LIMIT = 2'd1;

    // Configuration reset values
    localparam logic [PauseW-1:0]   PAUSE_TICKS_RST   = 16'd5;
    localparam logic [StretchW-1:0] STRETCH_LIMIT_RST = 9'd256;

    // Bit sequencing constants
    localparam logic [ByteW-1:0]   BYTE_MSB   = 8'h80;
    localparam logic [ByteW-1:0]   BYTE_ONES  = 8'hFF;
    localparam logic [BitIdxW-1:0] BITS_DATA  = 4'd8;

    // Sequencer phases, one-hot
    typedef enum logic [9:0] {
        PH_IDLE    = 10'b00_0000_0001,
        PH_ST1     = 10'b00_0000_0010,
        PH_ST2     = 10'b00_0000_0100,
        PH_ST3     = 10'b00_0000_1000,
        PH_SP1     = 10'b00_0001_0000,
        PH_SP2     = 10'b00_0010_0000,
        PH_SP3     = 10'b00_0100_0000,
        PH_SETUP   = 10'b00_1000_0000,
        PH_STRETCH = 10'b01_0000_0000,
        PH_HIGH    = 10'b10_0000_0000
    } t_phase;

endpackage

// ===== hw/rtl/i2cbb_in_if.sv =====
// Tick request channel of the I2C bit-bang master: command and sampled lines.
// Depends on i2cbb_pkg.
interface i2cbb_in_if;
    logic                          valid;
    logic                          ready;
    logic [i2cbb_pkg::FuncW-1:0]   func;
    logic [i2cbb_pkg::ByteW-1:0]   tx_byte;
    logic                          ack_bit;
    logic                          scl_in;
    logic                          sda_in;

    modport source (output valid, func, tx_byte, ack_bit, scl_in, sda_in, input ready);
    modport sink   (input valid, func, tx_byte, ack_bit, scl_in, sda_in, output ready);
endinterface

// ===== hw/rtl/i2cbb_out_if.sv =====
// Result channel of the I2C bit-bang master: line drives and status.
// Depends on i2cbb_pkg.
interface i2cbb_out_if;
    logic                          valid;
    logic                          ready;
    logic                          sda_low;
    logic                          scl_low;
    logic                          busy_res;
    logic                          done_res;
    logic [i2cbb_pkg::ByteW-1:0]   rx_byte;
    logic                          nack;

    modport source (output valid, sda_low, scl_low, busy_res, done_res, rx_byte, nack,
                    input ready);
    modport sink   (input valid, sda_low, scl_low, busy_res, done_res, rx_byte, nack,
                    output ready);
endinterface

// ===== hw/rtl/i2cbb_cfg_if.sv =====
// Configuration write channel of the I2C bit-bang master.
// Depends on i2cbb_pkg.
interface i2cbb_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [i2cbb_pkg::CfgIdxW-1:0]    index;
    logic [i2cbb_pkg::CfgDataW-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/i2c_bitbang_master_top.sv =====
// Top level of the tick-driven open-drain I2C master byte controller.
// Depends on i2cbb_pkg, i2cbb_in_if, i2cbb_out_if, i2cbb_cfg_if.
//
//  channel  | dir | carries
//  ---------+-----+----------------------------------------------------
//  i_in     | in  | one tick: func, tx_byte, ack_bit, scl_in, sda_in
//  i_cfg    | in  | register write: index (0 pause_ticks, 1 stretch_limit)
//  o_out    | out | one result per tick: sda_low, scl_low, busy, done,
//           |     | rx_byte, nack
//
// One tick request per clock while i_in.ready is high; its result appears in the
// output register the next cycle. The state update and result logic sit between
// the sequencer registers and the output register.
// i_in.ready drops only while a result is held and o_out.ready is low.
// Synchronous active-low reset idles the sequencer, releases both lines and
// loads pause_ticks = 5, stretch_limit = 256. i_cfg is always ready.
module i2c_bitbang_master_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    i2cbb_in_if.sink           i_in,
    i2cbb_cfg_if.sink          i_cfg,
    i2cbb_out_if.source        o_out
);

    // Configuration registers
    logic [i2cbb_pkg::PauseW-1:0]   r_pause_ticks;
    logic [i2cbb_pkg::StretchW-1:0] r_stretch_limit;

    // Sequencer state
    i2cbb_pkg::t_phase              r_phase,         n_phase;
    logic [i2cbb_pkg::PauseW-1:0]   r_pause_count,   n_pause_count;
    logic [i2cbb_pkg::StretchW-1:0] r_stretch_count, n_stretch_count;
    logic [i2cbb_pkg::ByteW-1:0]    r_shift,         n_shift;
    logic [i2cbb_pkg::BitIdxW-1:0]  r_bit_index,     n_bit_index;
    logic                           r_is_read,       n_is_read;
    logic                           r_ack_to_send,   n_ack_to_send;
    logic                           r_drive_sda,     n_drive_sda;
    logic                           r_drive_scl,     n_drive_scl;
    logic [i2cbb_pkg::ByteW-1:0]    r_last_rx,       n_last_rx;
    logic                           r_last_nack,     n_last_nack;

    // Output register
    logic                           r_out_valid;
    logic                           r_out_sda_low;
    logic                           r_out_scl_low;
    logic                           r_out_busy;
    logic                           r_out_done;
    logic [i2cbb_pkg::ByteW-1:0]    r_out_rx;
    logic                           r_out_nack;

    logic                           in_ready;
    logic                           in_accept;
    logic                           done;
    logic [i2cbb_pkg::PauseW-1:0]   pause_len;
    logic [i2cbb_pkg::PauseW-1:0]   pause_inc;
    logic                           pause_elapsed;
    logic [i2cbb_pkg::PauseW-1:0]   pause_next;
    logic [i2cbb_pkg::BitIdxW-1:0]  bit_index_inc;
    logic [i2cbb_pkg::ByteW-1:0]    shift_in;

    // Handshake: output register frees when empty or being taken
    assign in_ready    = !r_out_valid || o_out.ready;
    assign in_accept   = i_in.valid && in_ready;
    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    // Pause counter step; zero length acts as one
    assign pause_len     = (r_pause_ticks == '0) ? {{(i2cbb_pkg::PauseW-1){1'b0}}, 1'b1}
                                                 : r_pause_ticks;
    assign pause_inc     = r_pause_count + 1'b1;
    assign pause_elapsed = (pause_inc >= pause_len);
    assign pause_next    = pause_elapsed ? '0 : pause_inc;

    assign bit_index_inc = r_bit_index + 1'b1;
    assign shift_in      = {r_shift[i2cbb_pkg::ByteW-2:0], i_in.sda_in};

    // Next-state logic for one tick
    always_comb begin
        n_phase         = r_phase;
        n_pause_count   = r_pause_count;
        n_stretch_count = r_stretch_count;
        n_shift         = r_shift;
        n_bit_index     = r_bit_index;
        n_is_read       = r_is_read;
        n_ack_to_send   = r_ack_to_send;
        n_drive_sda     = r_drive_sda;
        n_drive_scl     = r_drive_scl;
        n_last_rx       = r_last_rx;
        n_last_nack     = r_last_nack;
        done            = 1'b0;

        case (r_phase)
            i2cbb_pkg::PH_IDLE: begin
                n_pause_count = '0;
                case (i_in.func)
                    i2cbb_pkg::FUNC_START: begin
                        n_drive_sda = 1'b0;
                        n_drive_scl = 1'b0;
                        n_phase     = i2cbb_pkg::PH_ST1;
                    end
                    i2cbb_pkg::FUNC_STOP: begin
                        n_drive_sda = 1'b1;
                        n_drive_scl = 1'b1;
                        n_phase     = i2cbb_pkg::PH_SP1;
                    end
                    i2cbb_pkg::FUNC_WRITE, i2cbb_pkg::FUNC_READ: begin
                        n_is_read     = (i_in.func == i2cbb_pkg::FUNC_READ);
                        n_ack_to_send = i_in.ack_bit;
                        n_shift       = n_is_read ? i2cbb_pkg::BYTE_ONES : i_in.tx_byte;
                        n_bit_index   = '0;
                        n_drive_sda   = !n_shift[i2cbb_pkg::ByteW-1];
                        n_phase       = i2cbb_pkg::PH_SETUP;
                    end
                    default: begin
                    end
                endcase
            end
            i2cbb_pkg::PH_ST1: begin
                n_pause_count = pause_next;
                if (pause_elapsed) begin
                    n_drive_sda = 1'b1;
                    n_phase     = i2cbb_pkg::PH_ST2;
                end
            end
            i2cbb_pkg::PH_ST2: begin
                n_pause_count = pause_next;
                if (pause_elapsed) begin
                    n_drive_scl = 1'b1;
                    n_phase     = i2cbb_pkg::PH_ST3;
                end
            end
            i2cbb_pkg::PH_SP1: begin
                n_pause_count = pause_next;
                if (pause_elapsed) begin
                    n_drive_scl = 1'b0;
                    n_phase     = i2cbb_pkg::PH_SP2;
                end
            end
            i2cbb_pkg::PH_SP2: begin
                n_pause_count = pause_next;
                if (pause_elapsed) begin
                    n_drive_sda = 1'b0;
                    n_phase     = i2cbb_pkg::PH_SP3;
                end
            end
            i2cbb_pkg::PH_ST3, i2cbb_pkg::PH_SP3: begin
                n_pause_count = pause_next;
                if (pause_elapsed) begin
                    n_phase = i2cbb_pkg::PH_IDLE;
                    done    = 1'b1;
                end
            end
            i2cbb_pkg::PH_SETUP: begin
                n_pause_count = pause_next;
                if (pause_elapsed) begin
                    n_drive_scl     = 1'b0;
                    n_stretch_count = '0;
                    n_phase         = i2cbb_pkg::PH_STRETCH;
                end
            end
            // Wait for SCL released by the slave, bounded by stretch_limit pauses
            i2cbb_pkg::PH_STRETCH: begin
                if (i_in.scl_in || (r_stretch_count >= r_stretch_limit)) begin
                    n_pause_count = '0;
                    n_phase       = i2cbb_pkg::PH_HIGH;
                end else begin
                    n_pause_count = pause_next;
                    if (pause_elapsed) begin
                        n_stretch_count = r_stretch_count + 1'b1;
                    end
                end
            end
            // SCL high: sample SDA at the end of the pause, then pull SCL low
            i2cbb_pkg::PH_HIGH: begin
                n_pause_count = pause_next;
                if (pause_elapsed) begin
                    n_drive_scl = 1'b1;
                    n_shift     = shift_in;
                    n_bit_index = bit_index_inc;
                    if (bit_index_inc < i2cbb_pkg::BITS_DATA) begin
                        n_drive_sda   = !shift_in[i2cbb_pkg::ByteW-1];
                        n_pause_count = '0;
                        n_phase       = i2cbb_pkg::PH_SETUP;
                    end else if (bit_index_inc == i2cbb_pkg::BITS_DATA) begin
                        // Acknowledge slot
                        if (r_is_read) begin
                            n_last_rx = shift_in;
                            n_shift   = r_ack_to_send ? i2cbb_pkg::BYTE_MSB : '0;
                        end else begin
                            n_shift   = i2cbb_pkg::BYTE_MSB;
                        end
                        n_drive_sda   = !n_shift[i2cbb_pkg::ByteW-1];
                        n_pause_count = '0;
                        n_phase       = i2cbb_pkg::PH_SETUP;
                    end else begin
                        if (!r_is_read) begin
                            n_last_nack = i_in.sda_in;
                        end
                        n_phase = i2cbb_pkg::PH_IDLE;
                        done    = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = i2cbb_pkg::PH_IDLE;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pause_ticks   <= i2cbb_pkg::PAUSE_TICKS_RST;
            r_stretch_limit <= i2cbb_pkg::STRETCH_LIMIT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                i2cbb_pkg::CFG_PAUSE_TICKS:   r_pause_ticks   <= i_cfg.data;
                i2cbb_pkg::CFG_STRETCH_LIMIT: r_stretch_limit <=
                                                  i_cfg.data[i2cbb_pkg::StretchW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer state, advanced once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= i2cbb_pkg::PH_IDLE;
            r_pause_count   <= '0;
            r_stretch_count <= '0;
            r_shift         <= '0;
            r_bit_index     <= '0;
            r_is_read       <= 1'b0;
            r_ack_to_send   <= 1'b0;
            r_drive_sda     <= 1'b0;
            r_drive_scl     <= 1'b0;
            r_last_rx       <= '0;
            r_last_nack     <= 1'b0;
        end else if (in_accept) begin
            r_phase         <= n_phase;
            r_pause_count   <= n_pause_count;
            r_stretch_count <= n_stretch_count;
            r_shift         <= n_shift;
            r_bit_index     <= n_bit_index;
            r_is_read       <= n_is_read;
            r_ack_to_send   <= n_ack_to_send;
            r_drive_sda     <= n_drive_sda;
            r_drive_scl     <= n_drive_scl;
            r_last_rx       <= n_last_rx;
            r_last_nack     <= n_last_nack;
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_sda_low <= n_drive_sda;
            r_out_scl_low <= n_drive_scl;
            r_out_busy    <= (n_phase != i2cbb_pkg::PH_IDLE);
            r_out_done    <= done;
            r_out_rx      <= n_last_rx;
            r_out_nack    <= n_last_nack;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.sda_low  = r_out_sda_low;
    assign o_out.scl_low  = r_out_scl_low;
    assign o_out.busy_res = r_out_busy;
    assign o_out.done_res = r_out_done;
    assign o_out.rx_byte  = r_out_rx;
    assign o_out.nack     = r_out_nack;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the tick-driven I2C bit-bang master byte controller.
// Depends on i2cbb_pkg, the three channel interfaces and i2c_bitbang_master_top.
`timescale 1ns / 1ps

module tb_top;

    localparam int          CLK_PERIOD     = 20;
    localparam int          RST_CYCLES     = 11;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int unsigned ITEMS_TARGET   = 450;
    localparam int          MAX_PRINTS     = 40;

    // One tick request and one line status result
    typedef struct packed {
        logic [i2cbb_pkg::FuncW-1:0] func;
        logic [i2cbb_pkg::ByteW-1:0] tx_byte;
        logic                        ack_bit;
        logic                        scl_in;
        logic                        sda_in;
    } t_tick;

    typedef struct packed {
        logic                        sda_low;
        logic                        scl_low;
        logic                        busy_res;
        logic                        done_res;
        logic [i2cbb_pkg::ByteW-1:0] rx_byte;
        logic                        nack;
    } t_line_status;

    // How the fake slave drives SDA
    typedef enum logic [1:0] {SDA_FOLLOW, SDA_HIGH, SDA_LOW} t_sda_drive;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    i2cbb_in_if  tick_ch ();
    i2cbb_cfg_if cfg_ch ();
    i2cbb_out_if status_ch ();

    i2c_bitbang_master_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_ch),
        .i_cfg   (cfg_ch),
        .o_out   (status_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Predicted sequencer state and configuration
    i2cbb_pkg::t_phase              ph          = i2cbb_pkg::PH_IDLE;
    logic [i2cbb_pkg::PauseW-1:0]   pcnt        = '0;
    logic [i2cbb_pkg::PauseW-1:0]   cfg_pause   = i2cbb_pkg::PAUSE_TICKS_RST;
    logic [i2cbb_pkg::StretchW-1:0] scnt        = '0;
    logic [i2cbb_pkg::StretchW-1:0] cfg_stretch = i2cbb_pkg::STRETCH_LIMIT_RST;
    logic [i2cbb_pkg::ByteW-1:0]    shreg       = '0;
    logic [i2cbb_pkg::ByteW-1:0]    rx_last     = '0;
    logic [i2cbb_pkg::BitIdxW-1:0]  bidx        = '0;
    logic                           rd_op       = 1'b0;
    logic                           ack_out     = 1'b0;
    logic                           sda_drv     = 1'b0;
    logic                           scl_drv     = 1'b0;
    logic                           nack_last   = 1'b0;

    t_line_status pending[$];

    // Stimulus knobs and bookkeeping
    t_sda_drive  sda_mode     = SDA_FOLLOW;
    bit          line_noise   = 1'b0;
    bit          idle_en      = 1'b1;
    int unsigned scl_hold     = 0;
    int unsigned src_calm     = 0;
    int unsigned sink_calm    = 0;
    int unsigned sink_stall   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned err_cnt      = 0;
    int unsigned ticks_sent   = 0;
    int unsigned cmds_issued  = 0;
    int unsigned results_seen = 0;
    int unsigned reg_writes   = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One pause step; true on the tick that ends the pause
    function automatic logic pause_elapsed();
        logic [i2cbb_pkg::PauseW-1:0] len;
        len  = (cfg_pause == '0) ? 16'd1 : cfg_pause;
        pcnt = pcnt + 1'b1;
        if (pcnt >= len) begin
            pcnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Put the shift register MSB on SDA and start the setup pause
    function automatic void drive_bit();
        sda_drv = ~shreg[i2cbb_pkg::ByteW-1];
        pcnt    = '0;
        ph      = i2cbb_pkg::PH_SETUP;
    endfunction

    function automatic t_line_status next_line_status(input t_tick t);
        t_line_status r;
        logic         fin;
        fin = 1'b0;
        case (ph)
            i2cbb_pkg::PH_IDLE: begin
                pcnt = '0;
                if (t.func == i2cbb_pkg::FUNC_START) begin
                    sda_drv = 1'b0;
                    scl_drv = 1'b0;
                    ph      = i2cbb_pkg::PH_ST1;
                end else if (t.func == i2cbb_pkg::FUNC_STOP) begin
                    sda_drv = 1'b1;
                    scl_drv = 1'b1;
                    ph      = i2cbb_pkg::PH_SP1;
                end else if (t.func == i2cbb_pkg::FUNC_WRITE ||
                             t.func == i2cbb_pkg::FUNC_READ) begin
                    rd_op   = (t.func == i2cbb_pkg::FUNC_READ);
                    ack_out = t.ack_bit;
                    shreg   = rd_op ? i2cbb_pkg::BYTE_ONES : t.tx_byte;
                    bidx    = '0;
                    drive_bit();
                end
            end
            i2cbb_pkg::PH_ST1: if (pause_elapsed()) begin
                sda_drv = 1'b1;
                ph      = i2cbb_pkg::PH_ST2;
            end
            i2cbb_pkg::PH_ST2: if (pause_elapsed()) begin
                scl_drv = 1'b1;
                ph      = i2cbb_pkg::PH_ST3;
            end
            i2cbb_pkg::PH_SP1: if (pause_elapsed()) begin
                scl_drv = 1'b0;
                ph      = i2cbb_pkg::PH_SP2;
            end
            i2cbb_pkg::PH_SP2: if (pause_elapsed()) begin
                sda_drv = 1'b0;
                ph      = i2cbb_pkg::PH_SP3;
            end
            i2cbb_pkg::PH_ST3, i2cbb_pkg::PH_SP3: if (pause_elapsed()) begin
                ph  = i2cbb_pkg::PH_IDLE;
                fin = 1'b1;
            end
            i2cbb_pkg::PH_SETUP: if (pause_elapsed()) begin
                scl_drv = 1'b0;
                scnt    = '0;
                ph      = i2cbb_pkg::PH_STRETCH;
            end
            // SCL checked every tick; give up once the stretch count hits the limit
            i2cbb_pkg::PH_STRETCH: begin
                if (t.scl_in || scnt >= cfg_stretch) begin
                    pcnt = '0;
                    ph   = i2cbb_pkg::PH_HIGH;
                end else if (pause_elapsed()) begin
                    scnt = scnt + 1'b1;
                end
            end
            // End of the high half: sample SDA, pull SCL, move to the next bit or finish
            i2cbb_pkg::PH_HIGH: if (pause_elapsed()) begin
                scl_drv = 1'b1;
                shreg   = {shreg[i2cbb_pkg::ByteW-2:0], t.sda_in};
                bidx    = bidx + 1'b1;
                if (bidx < i2cbb_pkg::BITS_DATA) begin
                    drive_bit();
                end else if (bidx == i2cbb_pkg::BITS_DATA) begin
                    if (rd_op) begin
                        rx_last = shreg;
                        shreg   = ack_out ? i2cbb_pkg::BYTE_MSB : '0;
                    end else begin
                        shreg = i2cbb_pkg::BYTE_MSB;
                    end
                    drive_bit();
                end else begin
                    if (!rd_op)
                        nack_last = t.sda_in;
                    ph  = i2cbb_pkg::PH_IDLE;
                    fin = 1'b1;
                end
            end
            default: ph = i2cbb_pkg::PH_IDLE;
        endcase
        r.sda_low  = sda_drv;
        r.scl_low  = scl_drv;
        r.busy_res = (ph != i2cbb_pkg::PH_IDLE);
        r.done_res = fin;
        r.rx_byte  = rx_last;
        r.nack     = nack_last;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Idle gap length: mostly none or short, now and then long
    function automatic int unsigned idle_len();
        if (!idle_en)
            return 0;
        case ($urandom_range(0, 31))
            0:                return $urandom_range(12, 40);
            1, 2, 3, 4, 5, 6: return $urandom_range(1, 3);
            default:          return 0;
        endcase
    endfunction

    // Build a tick with line levels from a simple slave model
    function automatic t_tick make_tick(input logic [i2cbb_pkg::FuncW-1:0] f,
                                        input logic [i2cbb_pkg::ByteW-1:0] b,
                                        input logic a);
        t_tick t;
        t.func    = f;
        t.tx_byte = b;
        t.ack_bit = a;
        if (ph == i2cbb_pkg::PH_STRETCH) begin
            if (scl_hold != 0) begin
                t.scl_in = 1'b0;
                scl_hold--;
            end else begin
                t.scl_in = line_noise ? ($urandom_range(0, 3) != 0) : 1'b1;
            end
        end else begin
            t.scl_in = ~scl_drv;
            if (line_noise && $urandom_range(0, 15) == 0)
                t.scl_in = ~t.scl_in;
        end
        case (sda_mode)
            SDA_HIGH: t.sda_in = 1'b1;
            SDA_LOW:  t.sda_in = 1'b0;
            default:  t.sda_in = sda_drv ? 1'b0 : 1'($urandom_range(0, 1));
        endcase
        return t;
    endfunction

    // Send one tick request; prediction is made at the accepting edge
    task automatic send_tick(input t_tick t);
        int unsigned gap;
        if (src_calm != 0) begin
            src_calm--;
            gap = 0;
        end else begin
            gap = idle_len();
            if ($urandom_range(0, 39) == 0)
                src_calm = $urandom_range(50, 200);
        end
        repeat (gap) @(negedge i_clk);
        tick_ch.func    = t.func;
        tick_ch.tx_byte = t.tx_byte;
        tick_ch.ack_bit = t.ack_bit;
        tick_ch.scl_in  = t.scl_in;
        tick_ch.sda_in  = t.sda_in;
        tick_ch.valid   = 1'b1;
        do @(posedge i_clk); while (!tick_ch.ready);
        pending.push_back(next_line_status(t));
        ticks_sent++;
        @(negedge i_clk);
        tick_ch.valid = 1'b0;
    endtask

    // Issue a command and keep ticking until the sequencer is idle again
    task automatic run_command(input logic [i2cbb_pkg::FuncW-1:0] f,
                               input logic [i2cbb_pkg::ByteW-1:0] b, input logic a);
        logic [i2cbb_pkg::FuncW-1:0] busy_f;
        send_tick(make_tick(f, b, a));
        if (ph != i2cbb_pkg::PH_IDLE)
            cmds_issued++;
        while (ph != i2cbb_pkg::PH_IDLE) begin
            // the odd command while busy must be ignored
            busy_f = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(1, 7))
                                                 : i2cbb_pkg::FUNC_TICK;
            send_tick(make_tick(busy_f, 8'($urandom), 1'($urandom)));
        end
    endtask

    task automatic wait_results_drained();
        while (pending.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Register write, only once every pending result is back
    task automatic write_reg(input logic [i2cbb_pkg::CfgIdxW-1:0]  idx,
                             input logic [i2cbb_pkg::CfgDataW-1:0] val);
        wait_results_drained();
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        cfg_ch.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == i2cbb_pkg::CFG_PAUSE_TICKS)
            cfg_pause = val;
        else if (idx == i2cbb_pkg::CFG_STRETCH_LIMIT)
            cfg_stretch = val[i2cbb_pkg::StretchW-1:0];
        reg_writes++;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                      results_seen, name, got, want));
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_line_status want;
        if (i_rst_n && status_ch.valid && status_ch.ready) begin
            results_seen++;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no tick pending",
                                          results_seen));
            end else begin
                want = pending.pop_front();
                check_field("sda_low", 32'(status_ch.sda_low), 32'(want.sda_low));
                check_field("scl_low", 32'(status_ch.scl_low), 32'(want.scl_low));
                check_field("busy_res", 32'(status_ch.busy_res), 32'(want.busy_res));
                check_field("done_res", 32'(status_ch.done_res), 32'(want.done_res));
                check_field("rx_byte", 32'(status_ch.rx_byte), 32'(want.rx_byte));
                check_field("nack", 32'(status_ch.nack), 32'(want.nack));
            end
        end
    end

    // Result sink: random stalls with calm stretches
    always @(negedge i_clk) begin
        if (sink_stall != 0) begin
            sink_stall--;
            status_ch.ready = 1'b0;
        end else begin
            status_ch.ready = 1'b1;
            if (sink_calm != 0)
                sink_calm--;
            else if ($urandom_range(0, 39) == 0)
                sink_calm = $urandom_range(50, 200);
            else
                sink_stall = idle_len();
        end
    end

    // Watchdog on cycles with no request moving on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_ch.valid && tick_ch.ready) ||
            (status_ch.valid && status_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no request moved for %0d cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Full transfer with the reset configuration
    task automatic test_reset_settings();
        run_command(i2cbb_pkg::FUNC_START, 8'h00, 1'b0);
        run_command(i2cbb_pkg::FUNC_WRITE, 8'hA5, 1'b0);
        run_command(i2cbb_pkg::FUNC_STOP, 8'h00, 1'b0);
    endtask

    // Data and acknowledge extremes
    task automatic test_byte_extremes();
        write_reg(i2cbb_pkg::CFG_PAUSE_TICKS, 16'd1);
        write_reg(i2cbb_pkg::CFG_STRETCH_LIMIT, 16'd2);
        sda_mode = SDA_LOW;
        run_command(i2cbb_pkg::FUNC_WRITE, 8'h00, 1'b0);
        sda_mode = SDA_HIGH;
        run_command(i2cbb_pkg::FUNC_WRITE, 8'hFF, 1'b1);
        run_command(i2cbb_pkg::FUNC_READ, 8'h00, 1'b1);
        sda_mode = SDA_FOLLOW;
    endtask

    // Unused codes while idle, command codes in turn while busy
    task automatic test_busy_and_unused_codes();
        logic [i2cbb_pkg::FuncW-1:0] code;
        run_command(i2cbb_pkg::FUNC_TICK, 8'hFF, 1'b1);
        for (int c = 5; c < 8; c++)
            run_command(3'(c), 8'($urandom), 1'($urandom));
        send_tick(make_tick(i2cbb_pkg::FUNC_START, 8'h00, 1'b0));
        cmds_issued++;
        code = i2cbb_pkg::FUNC_START;
        while (ph != i2cbb_pkg::PH_IDLE) begin
            send_tick(make_tick(code, 8'($urandom), 1'($urandom)));
            code = (code == 3'd7) ? i2cbb_pkg::FUNC_START : code + 1'b1;
        end
        run_command(i2cbb_pkg::FUNC_STOP, 8'h00, 1'b0);
    endtask

    // Slave holding SCL: give-up, zero limit, largest limit with early release
    task automatic test_clock_stretch();
        write_reg(i2cbb_pkg::CFG_STRETCH_LIMIT, 16'd2);
        scl_hold = 100;
        run_command(i2cbb_pkg::FUNC_WRITE, 8'hC3, 1'b0);
        write_reg(i2cbb_pkg::CFG_STRETCH_LIMIT, 16'd0);
        scl_hold = 100;
        run_command(i2cbb_pkg::FUNC_READ, 8'h00, 1'b1);
        // upper data bits fall outside the 9-bit register
        write_reg(i2cbb_pkg::CFG_STRETCH_LIMIT, 16'hFFFF);
        scl_hold = 12;
        run_command(i2cbb_pkg::FUNC_READ, 8'h00, 1'b0);
        scl_hold = 0;
    endtask

    // Zero pause acts as one
    task automatic test_pause_zero();
        write_reg(i2cbb_pkg::CFG_PAUSE_TICKS, 16'd0);
        write_reg(i2cbb_pkg::CFG_STRETCH_LIMIT, 16'd256);
        run_command(i2cbb_pkg::FUNC_START, 8'h00, 1'b0);
        run_command(i2cbb_pkg::FUNC_WRITE, 8'h96, 1'b0);
        run_command(i2cbb_pkg::FUNC_STOP, 8'h00, 1'b0);
    endtask

    // Random commands under changing settings, with line noise
    task automatic test_random_traffic();
        logic [i2cbb_pkg::CfgDataW-1:0] pv;
        logic [i2cbb_pkg::CfgDataW-1:0] sv;
        logic [i2cbb_pkg::FuncW-1:0]    f;
        line_noise = 1'b1;
        sda_mode   = SDA_FOLLOW;
        while (ticks_sent < ITEMS_TARGET) begin
            // new settings now and then
            if ($urandom_range(0, 3) == 0) begin
                pv = 16'($urandom_range(0, 2));
                case ($urandom_range(0, 2))
                    0:       sv = 16'd0;
                    1:       sv = 16'h01FF;
                    default: sv = 16'($urandom_range(1, 8));
                endcase
                write_reg(i2cbb_pkg::CFG_PAUSE_TICKS, pv);
                write_reg(i2cbb_pkg::CFG_STRETCH_LIMIT, sv);
            end
            // mostly real commands, now and then any code
            f = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7))
                                            : 3'($urandom_range(1, 4));
            run_command(f, 8'($urandom), 1'($urandom));
            // now and then the sender holds off until every result is back
            if ($urandom_range(0, 9) == 0)
                wait_results_drained();
        end
        line_noise = 1'b0;
    endtask

    initial begin
        tick_ch.valid   = 1'b0;
        tick_ch.func    = i2cbb_pkg::FUNC_TICK;
        tick_ch.tx_byte = '0;
        tick_ch.ack_bit = 1'b0;
        tick_ch.scl_in  = 1'b1;
        tick_ch.sda_in  = 1'b1;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = i2cbb_pkg::CFG_PAUSE_TICKS;
        cfg_ch.data     = '0;
        status_ch.ready = 1'b1;

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_settings();
        test_byte_extremes();
        test_busy_and_unused_codes();
        test_clock_stretch();
        test_pause_zero();
        test_random_traffic();

        wait_results_drained();
        repeat (4) @(posedge i_clk);
        if (pending.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived", pending.size()));

        $display("Covered %0d ticks, %0d commands, %0d results checked, %0d register writes",
                 ticks_sent, cmds_issued, results_seen, reg_writes);
        $display("Pauses 0/1/5 and random, stretch limits 0..511, nack, ignored commands");
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
